// ----- hdl/lbi_pkg.sv -----
// ----------------------------------------------------------------------------
// lbi_pkg
// Types and arithmetic helpers for the 3D color table interpolator.
// ----------------------------------------------------------------------------
package lbi_pkg;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] table_address;
    logic [23:0] table_rgb;
    logic [7:0]  pix_alpha;
    logic [7:0]  pix_red;
    logic [7:0]  pix_green;
    logic [7:0]  pix_blue;
    logic        pix_last;
  } req_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_last;
  } rsp_t;

  typedef struct packed {
    logic [7:0] quo;
    logic [7:0] rem;
  } div255_t;

  localparam logic [7:0] CHAN_MAX  = 8'hFF;
  localparam logic [7:0] HALF_STEP = 8'd128;

  // x / 255 and x % 255, exact for x <= 255*255
  function automatic div255_t div255(input logic [15:0] x);
    logic [16:0] s;
    div255_t     d;
    s     = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    d.quo = s[15:8];
    d.rem = 8'(x - {d.quo, 8'd0} + {8'd0, d.quo});
    return d;
  endfunction

  // round(x / 255); ties cannot occur since 255 is odd
  function automatic logic [7:0] round255(input logic [15:0] x);
    div255_t d;
    d = div255(x);
    return d.quo + {7'd0, (d.rem >= HALF_STEP)};
  endfunction

endpackage

// ----- hdl/lbi_if.sv -----
// ----------------------------------------------------------------------------
// lbi_req_if / lbi_rsp_if
// Valid/ready stream channels for requests and results.
// ----------------------------------------------------------------------------
interface lbi_req_if;
  import lbi_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbi_rsp_if;
  import lbi_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/lbi_ram.sv -----
// ----------------------------------------------------------------------------
// lbi_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lbi_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lut3d_blue_interp_apply.sv -----
// ----------------------------------------------------------------------------
// lut3d_blue_interp_apply
// 3D color table on an ARGB stream: red/green snap to nearest grid index,
// blue interpolates linearly between floor and ceiling slices.
//
//   channel | dir | handshake          | payload
//   req     | in  | req.valid/ready    | cmd, table write or pixel
//   rsp     | out | rsp.valid/ready    | ARGB result, last mark
//
// One request per cycle sustained while rsp.ready holds. A pixel result
// passes registered stages for products, index snap, table read, lerp, round.
// Table writes travel the same pipe and hit the RAMs in the read stage, so
// reads and writes stay in request order. The table is held twice, one copy
// per read port. Synchronous reset clears only the stage valid bits.
// A stalled stage holds; empty stages ahead keep taking requests.
// ----------------------------------------------------------------------------
module lut3d_blue_interp_apply #(
  parameter int LUT_SIZE = 16
) (
  input logic       clk,
  input logic       rst,
  lbi_req_if.sink   req,
  lbi_rsp_if.source rsp
);
  import lbi_pkg::*;

  localparam int M     = LUT_SIZE - 1;
  localparam int IW    = $clog2(LUT_SIZE);
  localparam int NN    = LUT_SIZE * LUT_SIZE;
  localparam int DEPTH = NN * LUT_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 8 + IW;

  // stage 1: channel * M
  logic          v1, wr1;
  logic [PW-1:0] p1_r, p1_g, p1_b;
  logic [11:0]   waddr1;
  logic [23:0]   wrgb1;
  logic [7:0]    alpha1;
  logic          last1;

  // stage 2: grid indices, RAM access
  logic          v2, wr2;
  logic [IW-1:0] rx2, gy2, bfl2, bce2;
  logic [7:0]    frac2;
  logic [11:0]   waddr2;
  logic [23:0]   wrgb2;
  logic [7:0]    alpha2;
  logic          last2;

  // stage 3: table data
  logic          v3;
  logic [23:0]   rd0, rd1;
  logic [7:0]    frac3;
  logic [7:0]    alpha3;
  logic          last3;

  // stage 4: weighted sums
  logic          v4;
  logic [15:0]   x4_r, x4_g, x4_b;
  logic [7:0]    alpha4;
  logic          last4;

  // output register
  logic          ovalid;
  rsp_t          rsp_q;

  logic en1, go1, en2, go2, can3, go3, can4, go4, can_o;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, a0, a1;

  div255_t       dr, dg, db;
  logic [IW-1:0] rx_c, gy_c, bfl_c, bce_c;
  logic [15:0]   x_r, x_g, x_b;
  logic [7:0]    wf0, wf1;

  // handshake chain
  always_comb begin
    can_o = !ovalid || rsp.ready;
    go4   = v4 && can_o;
    can4  = !v4 || go4;
    go3   = v3 && can4;
    can3  = !v3 || go3;
    go2   = v2 && (wr2 || can3);
    en2   = !v2 || go2;
    go1   = v1 && en2;
    en1   = !v1 || go1;
  end

  assign req.ready = en1;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      wr1    <= (req.data.cmd == CMD_WRITE);
      p1_r   <= PW'(int'(req.data.pix_red) * M);
      p1_g   <= PW'(int'(req.data.pix_green) * M);
      p1_b   <= PW'(int'(req.data.pix_blue) * M);
      waddr1 <= req.data.table_address;
      wrgb1  <= req.data.table_rgb;
      alpha1 <= req.data.pix_alpha;
      last1  <= req.data.pix_last;
    end
  end

  // index snap and blue split
  always_comb begin
    dr    = div255(16'(p1_r));
    dg    = div255(16'(p1_g));
    db    = div255(16'(p1_b));
    rx_c  = IW'(dr.quo + {7'd0, (dr.rem >= HALF_STEP)});
    gy_c  = IW'(dg.quo + {7'd0, (dg.rem >= HALF_STEP)});
    bfl_c = IW'(db.quo);
    bce_c = (bfl_c == IW'(M)) ? bfl_c : bfl_c + IW'(1);
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      wr2    <= wr1;
      rx2    <= rx_c;
      gy2    <= gy_c;
      bfl2   <= bfl_c;
      bce2   <= bce_c;
      frac2  <= db.rem;
      waddr2 <= waddr1;
      wrgb2  <= wrgb1;
      alpha2 <= alpha1;
      last2  <= last1;
    end
  end

  always_comb begin
    a0        = AW'(int'(gy2) * NN + int'(bfl2) * LUT_SIZE + int'(rx2));
    a1        = AW'(int'(gy2) * NN + int'(bce2) * LUT_SIZE + int'(rx2));
    ram_waddr = AW'(waddr2);
    ram_we    = v2 && wr2 && (int'(waddr2) < DEPTH);
    ram_re    = v2 && !wr2 && can3;
  end

  lbi_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram_floor (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wrgb2),
    .re   (ram_re),
    .raddr(a0),
    .rdata(rd0)
  );

  lbi_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_ram_ceil (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wrgb2),
    .re   (ram_re),
    .raddr(a1),
    .rdata(rd1)
  );

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (can3) begin
      v3 <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      frac3  <= frac2;
      alpha3 <= alpha2;
      last3  <= last2;
    end
  end

  always_comb begin
    wf0 = CHAN_MAX - frac3;
    wf1 = frac3;
    x_r = 16'(rd0[23:16]) * 16'(wf0) + 16'(rd1[23:16]) * 16'(wf1);
    x_g = 16'(rd0[15:8])  * 16'(wf0) + 16'(rd1[15:8])  * 16'(wf1);
    x_b = 16'(rd0[7:0])   * 16'(wf0) + 16'(rd1[7:0])   * 16'(wf1);
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (can4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (can4) begin
      x4_r   <= x_r;
      x4_g   <= x_g;
      x4_b   <= x_b;
      alpha4 <= alpha3;
      last4  <= last3;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (can_o) begin
      ovalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (go4) begin
      rsp_q.out_alpha <= alpha4;
      rsp_q.out_red   <= round255(x4_r);
      rsp_q.out_green <= round255(x4_g);
      rsp_q.out_blue  <= round255(x4_b);
      rsp_q.out_last  <= last4;
    end
  end

  assign rsp.valid = ovalid;
  assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> v3)
    else $error("table read did not fill stage 3");

  a_empty_front_ready: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> v1)
    else $error("front stage empty but request refused");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(v4))
    else $error("result appeared without a stage 4 item");
`endif

endmodule
